[sv/bfh_pkg.sv]
// Shared constants, types and hash helpers for the Bloom filter unit.
// No dependencies; every other file in this block but bfh_ram uses this package.
`timescale 1ns / 1ps

package bfh_pkg;

  localparam int unsigned FILTER_BITS     = 4096;
  localparam int unsigned IDX_W           = $clog2(FILTER_BITS);
  localparam int unsigned ONES_W          = 13;
  localparam int unsigned DEF_PROBES      = 4;
  localparam int unsigned DEF_MAX_KEY_LEN = 32;

  localparam logic [31:0] HASH_BASIS  = 32'h811C_9DC5;
  localparam logic [31:0] HASH_PRIME  = 32'h0100_0193;
  localparam logic [7:0]  LOWER_A     = 8'h61;
  localparam logic [7:0]  LOWER_F     = 8'h66;
  localparam logic [7:0]  CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic        valid;
    logic        ovf;
    logic        query;
    logic [31:0] h1;
    logic [31:0] h2;
  } key_res_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[LOWER_A:LOWER_F]}) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] x;
    logic [31:0] p;
    x = h ^ {24'h000000, c};
    p = x * HASH_PRIME;
    return p;
  endfunction

endpackage

[sv/bfh_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module bfh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bfh_key_unit.sv]
// Key capture: folds and buffers key bytes, runs the first hash per beat and
// replays the buffer for the second hash. Uses bfh_pkg and bfh_ram.
`timescale 1ns / 1ps

module bfh_key_unit #(
  parameter int unsigned MAX_KEY_LEN = bfh_pkg::DEF_MAX_KEY_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic              query_i,
  output logic              ready_o,
  output bfh_pkg::key_res_t key_o,
  input  logic              take_i
);

  localparam int unsigned LEN_W = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned AW    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  typedef enum logic [1:0] {ST_CAPTURE, ST_REPLAY, ST_HOLD} state_e;

  state_e           state_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] rd_cnt_q;
  logic             pend_q;
  logic             ovf_q;
  logic [31:0]      h1_q;
  logic [31:0]      h2_q;
  logic             query_q;

  logic [7:0]  folded;
  logic        room;
  logic        issue;
  logic [7:0]  rdata;
  logic [31:0] h1_step;
  logic [31:0] h2_step;

  assign folded  = bfh_pkg::fold_byte(byte_i);
  assign room    = (len_q < LEN_W'(MAX_KEY_LEN));
  assign issue   = (state_q == ST_REPLAY) && (rd_cnt_q < len_q);
  assign h1_step = bfh_pkg::hash_step(h1_q, folded);
  assign h2_step = bfh_pkg::hash_step(h2_q, rdata);

  bfh_ram #(
    .WIDTH(8),
    .DEPTH(MAX_KEY_LEN)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (byte_valid_i && room),
    .waddr_i(len_q[AW-1:0]),
    .wdata_i(folded),
    .raddr_i(rd_cnt_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CAPTURE;
      len_q    <= '0;
      rd_cnt_q <= '0;
      pend_q   <= 1'b0;
      ovf_q    <= 1'b0;
      h1_q     <= bfh_pkg::HASH_BASIS;
    end else begin
      case (state_q)
        ST_CAPTURE: begin
          if (byte_valid_i) begin
            if (room) begin
              len_q <= len_q + LEN_W'(1);
              h1_q  <= h1_step;
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              rd_cnt_q <= '0;
              pend_q   <= 1'b0;
              state_q  <= room ? ST_REPLAY : ST_HOLD;
            end
          end
        end
        ST_REPLAY: begin
          if (issue) begin
            rd_cnt_q <= rd_cnt_q + LEN_W'(1);
          end
          pend_q <= issue;
          if (!issue && !pend_q) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (take_i) begin
            len_q   <= '0;
            h1_q    <= bfh_pkg::HASH_BASIS;
            ovf_q   <= 1'b0;
            state_q <= ST_CAPTURE;
          end
        end
        default: begin
          state_q <= ST_CAPTURE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CAPTURE && byte_valid_i && last_i) begin
      query_q <= query_i;
      h2_q    <= room ? h1_step : h1_q;
    end else if (state_q == ST_REPLAY && pend_q) begin
      h2_q <= h2_step;
    end
  end

  assign ready_o     = (state_q == ST_CAPTURE);
  assign key_o.valid = (state_q == ST_HOLD);
  assign key_o.ovf   = ovf_q;
  assign key_o.query = query_q;
  assign key_o.h1    = h1_q;
  assign key_o.h2    = h2_q | 32'd1;

endmodule

[sv/bfh_probe_unit.sv]
// Probe engine: clears the filter store after reset, runs the probe
// read-modify-writes, keeps the totals and holds the result register.
// Uses bfh_pkg and bfh_ram.
`timescale 1ns / 1ps

module bfh_probe_unit #(
  parameter int unsigned PROBES = bfh_pkg::DEF_PROBES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfh_pkg::key_res_t          key_i,
  output logic                       take_o,
  output logic                       clearing_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       answer_o,
  output logic                       status_o,
  output logic [31:0]                unique_o,
  output logic [31:0]                added_o,
  output logic [bfh_pkg::ONES_W-1:0] ones_o
);

  localparam int unsigned PW = (PROBES > 1) ? $clog2(PROBES) : 1;
  localparam int unsigned IW = bfh_pkg::IDX_W;
  localparam int unsigned OW = bfh_pkg::ONES_W;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK, ST_DONE} state_e;

  state_e        state_q;
  logic [IW-1:0] clr_q;
  logic [PW-1:0] pcnt_q;
  logic          fresh_q;
  logic          allset_q;
  logic          ovf_q;
  logic [31:0]   unique_q;
  logic [31:0]   added_q;
  logic [OW-1:0] ones_q;
  logic          out_valid_q;
  logic          res_answer_q;
  logic          res_status_q;
  logic [31:0]   res_unique_q;
  logic [31:0]   res_added_q;
  logic [OW-1:0] res_ones_q;
  logic [31:0]   sum_q;
  logic [31:0]   step_q;
  logic          query_q;

  logic          bit_rd;
  logic          out_free;
  logic          fin;
  logic          is_add;
  logic [IW-1:0] idx;

  assign idx      = sum_q[IW-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign fin      = (state_q == ST_DONE) && out_free;
  assign is_add   = !ovf_q && !query_q;

  bfh_ram #(
    .WIDTH(1),
    .DEPTH(bfh_pkg::FILTER_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   ((state_q == ST_CLEAR) || ((state_q == ST_CHECK) && !bit_rd && !query_q)),
    .waddr_i((state_q == ST_CLEAR) ? clr_q : idx),
    .wdata_i(state_q != ST_CLEAR),
    .raddr_i(idx),
    .rdata_o(bit_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      pcnt_q       <= '0;
      fresh_q      <= 1'b0;
      allset_q     <= 1'b1;
      ovf_q        <= 1'b0;
      unique_q     <= '0;
      added_q      <= '0;
      ones_q       <= '0;
      out_valid_q  <= 1'b0;
      res_answer_q <= 1'b0;
      res_status_q <= 1'b0;
      res_unique_q <= '0;
      res_added_q  <= '0;
      res_ones_q   <= '0;
    end else begin
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin) begin
        res_answer_q <= !ovf_q && (query_q ? allset_q : fresh_q);
        res_status_q <= ovf_q;
        res_unique_q <= unique_q + {31'd0, is_add && fresh_q};
        res_added_q  <= added_q + {31'd0, is_add};
        res_ones_q   <= ones_q;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == IW'(bfh_pkg::FILTER_BITS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (key_i.valid) begin
            fresh_q  <= 1'b0;
            allset_q <= 1'b1;
            pcnt_q   <= '0;
            ovf_q    <= key_i.ovf;
            state_q  <= key_i.ovf ? ST_DONE : ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!bit_rd) begin
            allset_q <= 1'b0;
            if (!query_q) begin
              fresh_q <= 1'b1;
              ones_q  <= ones_q + OW'(1);
            end
          end
          pcnt_q  <= pcnt_q + PW'(1);
          state_q <= (pcnt_q == PW'(PROBES - 1)) ? ST_DONE : ST_READ;
        end
        ST_DONE: begin
          if (out_free) begin
            if (is_add) begin
              added_q <= added_q + 32'd1;
              if (fresh_q) begin
                unique_q <= unique_q + 32'd1;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && key_i.valid) begin
      sum_q   <= key_i.h1;
      step_q  <= key_i.h2;
      query_q <= key_i.query;
    end else if (state_q == ST_CHECK) begin
      sum_q <= sum_q + step_q;
    end
  end

  assign take_o      = (state_q == ST_IDLE);
  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign answer_o    = res_answer_q;
  assign status_o    = res_status_q;
  assign unique_o    = res_unique_q;
  assign added_o     = res_added_q;
  assign ones_o      = res_ones_q;

endmodule

[sv/bloom_filter_fnv1a_double_hash_unit.sv]
// Bloom filter with FNV-1a double hashing; key bytes are accepted at one beat per cycle
// while tready is high. After the last beat the buffer is replayed for the second hash,
// the key goes to the probe engine, each probe is a read then a check, and the result is
// registered; a too-long key skips the probes. The next key's beats are taken while the
// previous key probes; output back-pressure stalls. After reset the filter store is
// cleared one bit per cycle, no beat is taken meanwhile. Uses bfh_pkg and submodules.
`timescale 1ns / 1ps

module bloom_filter_fnv1a_double_hash_unit #(
  parameter int unsigned PROBES      = bfh_pkg::DEF_PROBES,
  parameter int unsigned MAX_KEY_LEN = bfh_pkg::DEF_MAX_KEY_LEN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] key_byte
  input  logic        s_axis_tlast,  // key_last
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [0] answer, [32:1] unique_count,
                                     // [64:33] added_count, [77:65] set_bit_count
  output logic        m_axis_tuser   // status
);

  bfh_pkg::key_res_t            key;
  logic                         key_ready;
  logic                         take;
  logic                         clearing;
  logic                         answer;
  logic                         status;
  logic [31:0]                  unique_cnt;
  logic [31:0]                  added_cnt;
  logic [bfh_pkg::ONES_W-1:0]   ones_cnt;

  assign s_axis_tready = key_ready && !clearing;

  bfh_key_unit #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_key (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid && s_axis_tready),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .query_i     (s_axis_tuser),
    .ready_o     (key_ready),
    .key_o       (key),
    .take_i      (take)
  );

  bfh_probe_unit #(
    .PROBES(PROBES)
  ) u_probe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key),
    .take_o     (take),
    .clearing_o (clearing),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .answer_o   (answer),
    .status_o   (status),
    .unique_o   (unique_cnt),
    .added_o    (added_cnt),
    .ones_o     (ones_cnt)
  );

  assign m_axis_tdata = {2'b00, ones_cnt, added_cnt, unique_cnt, answer};
  assign m_axis_tuser = status;

endmodule

[tb/tb_bloom_filter_fnv1a_double_hash_unit.sv]
// Self-checking testbench for bloom_filter_fnv1a_double_hash_unit: key bytes stream in,
// one verdict beat per key comes out and is compared against a local Bloom filter model.
// Depends on bfh_pkg and the unit itself; needs nothing else.
`timescale 1ns / 1ps

module tb_bloom_filter_fnv1a_double_hash_unit;

  localparam int unsigned FILTER_BITS = bfh_pkg::FILTER_BITS;
  localparam int unsigned IDX_W       = bfh_pkg::IDX_W;
  localparam int unsigned ONES_W      = bfh_pkg::ONES_W;
  localparam logic [31:0] HASH_BASIS  = bfh_pkg::HASH_BASIS;
  localparam logic [31:0] HASH_PRIME  = bfh_pkg::HASH_PRIME;
  localparam logic [7:0]  LOWER_A     = bfh_pkg::LOWER_A;
  localparam logic [7:0]  LOWER_F     = bfh_pkg::LOWER_F;
  localparam logic [7:0]  CASE_OFFSET = bfh_pkg::CASE_OFFSET;

  localparam int unsigned PROBE_COUNT  = bfh_pkg::DEF_PROBES;
  localparam int unsigned MAX_KEY      = bfh_pkg::DEF_MAX_KEY_LEN;
  localparam int unsigned TEXT_MAX     = MAX_KEY + 8;
  localparam int unsigned RANDOM_BEATS = 870;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 100;

  localparam logic REQ_ADD     = 1'b0;
  localparam logic REQ_QUERY   = 1'b1;
  localparam logic ST_DONE     = 1'b0;
  localparam logic ST_TOO_LONG = 1'b1;

  typedef struct packed {
    logic              answer;
    logic              status;
    logic [31:0]       uniq;
    logic [31:0]       added;
    logic [ONES_W-1:0] ones;
  } verdict_t;

  typedef struct packed {
    logic     query;
    logic [7:0] kbyte;
    logic [7:0] reps;
    logic     last;
    logic     pinned;
    verdict_t v;
  } beat_row_t;

  typedef struct packed {
    logic [7:0]                len;
    logic [TEXT_MAX-1:0][7:0] text;
  } key_rec_t;

  localparam verdict_t NO_VERDICT      = '0;
  localparam verdict_t TOO_LONG_AT_RST = '{1'b0, ST_TOO_LONG, 32'd0, 32'd0, '0};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic        filter_bits [FILTER_BITS];
  logic [7:0]  key_bytes [MAX_KEY];
  int unsigned key_len;
  logic [31:0] run_hash;
  bit          key_overflow;
  logic [31:0] uniq_total;
  logic [31:0] add_total;
  logic [31:0] ones_total;

  verdict_t    pending_verdicts [$];
  key_rec_t    key_pool [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  beat_row_t dir_rows [31] = '{
    '{REQ_QUERY, 8'h41, 8'd1,  1'b1, 1'b1, NO_VERDICT},
    '{REQ_ADD,   8'hFF, 8'd33, 1'b1, 1'b1, TOO_LONG_AT_RST},
    '{REQ_QUERY, 8'h61, 8'd40, 1'b1, 1'b1, TOO_LONG_AT_RST},
    '{REQ_ADD,   8'h61, 8'd1,  1'b1, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h41, 8'd1,  1'b1, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h41, 8'd1,  1'b1, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h7A, 8'd32, 1'b1, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h7A, 8'd32, 1'b1, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h7A, 8'd31, 1'b1, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h01, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h00, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h60, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h66, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h67, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h40, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h46, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h47, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h80, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'hFF, 8'd1,  1'b1, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h01, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h00, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h60, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h46, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h67, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h40, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h66, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h47, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h80, 8'd1,  1'b0, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'hFF, 8'd1,  1'b1, 1'b0, NO_VERDICT},
    '{REQ_ADD,   8'h31, 8'd36, 1'b1, 1'b0, NO_VERDICT},
    '{REQ_QUERY, 8'h61, 8'd1,  1'b1, 1'b0, NO_VERDICT}
  };

  bloom_filter_fnv1a_double_hash_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Advances the filter model by one accepted key beat; returns 1 when the beat ends a key.
  function automatic bit bloom_predict(input logic query, input logic [7:0] raw,
                                       input logic last, output verdict_t v);
    logic [7:0]  c;
    logic [31:0] h2;
    logic [31:0] probe;
    bit          fresh;
    bit          all_set;
    c = raw;
    if (raw >= LOWER_A && raw <= LOWER_F) begin
      c = raw - CASE_OFFSET;
    end
    v = '0;
    if (key_len < MAX_KEY) begin
      key_bytes[key_len] = c;
      key_len++;
      run_hash = (run_hash ^ {24'd0, c}) * HASH_PRIME;
    end else begin
      key_overflow = 1'b1;
    end
    if (!last) begin
      return 1'b0;
    end
    if (key_overflow) begin
      v.status = ST_TOO_LONG;
    end else begin
      v.status = ST_DONE;
      h2 = run_hash;
      for (int unsigned i = 0; i < key_len; i++) begin
        h2 = (h2 ^ {24'd0, key_bytes[i]}) * HASH_PRIME;
      end
      h2[0] = 1'b1;
      fresh = 1'b0;
      all_set = 1'b1;
      for (int unsigned i = 0; i < PROBE_COUNT; i++) begin
        probe = run_hash + 32'(i) * h2;
        if (!filter_bits[probe[IDX_W-1:0]]) begin
          all_set = 1'b0;
          if (query == REQ_ADD) begin
            fresh = 1'b1;
            filter_bits[probe[IDX_W-1:0]] = 1'b1;
            ones_total++;
          end
        end
      end
      if (query == REQ_QUERY) begin
        v.answer = all_set;
      end else begin
        add_total++;
        if (fresh) begin
          uniq_total++;
          v.answer = 1'b1;
        end
      end
    end
    key_len = 0;
    run_hash = HASH_BASIS;
    key_overflow = 1'b0;
    v.uniq = uniq_total;
    v.added = add_total;
    v.ones = ones_total[ONES_W-1:0];
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic push_beat(input logic query, input logic [7:0] kbyte, input logic last,
                           input bit pinned, input verdict_t pinned_v);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= kbyte;
    s_axis_tlast  <= last;
    s_axis_tuser  <= last ? query : 1'($urandom_range(1));
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    if (bloom_predict(query, kbyte, last, v)) begin
      pending_verdicts.push_back(pinned ? pinned_v : v);
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("answer", 32'(want.answer), 32'(m_axis_tdata[0]));
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
        check_field("unique_count", want.uniq, m_axis_tdata[32:1]);
        check_field("added_count", want.added, m_axis_tdata[64:33]);
        check_field("set_bit_count", 32'(want.ones), 32'(m_axis_tdata[77:65]));
        check_field("tdata padding", 32'd0, 32'(m_axis_tdata[79:78]));
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    key_rec_t    k;
    logic        q;
    int unsigned beats;
    int unsigned pick;
    int unsigned len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 47;
    foreach (filter_bits[i]) begin
      filter_bits[i] = 1'b0;
    end
    key_len      = 0;
    run_hash     = HASH_BASIS;
    key_overflow = 1'b0;
    uniq_total   = '0;
    add_total    = '0;
    ones_total   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      for (int unsigned n = 1; n <= dir_rows[r].reps; n++) begin
        push_beat(dir_rows[r].query, dir_rows[r].kbyte,
                  dir_rows[r].last && (n == dir_rows[r].reps),
                  dir_rows[r].pinned, dir_rows[r].v);
      end
    end

    // Random keys: about a third of them replay earlier added keys with their case reshuffled.
    beats = 0;
    while (beats < RANDOM_BEATS) begin
      if (beats >= 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (beats >= RANDOM_BEATS / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 26;
      end
      k = '0;
      if (key_pool.size() > 0 && $urandom_range(99) < 35) begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
        for (int unsigned n = 0; n < k.len; n++) begin
          if ((k.text[n] | CASE_OFFSET) >= LOWER_A && (k.text[n] | CASE_OFFSET) <= LOWER_F &&
              $urandom_range(1) == 1) begin
            k.text[n] = k.text[n] ^ CASE_OFFSET;
          end
        end
        q = ($urandom_range(99) < 60) ? REQ_QUERY : REQ_ADD;
      end else begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          len = $urandom_range(TEXT_MAX, MAX_KEY + 1);
        end else if (pick < 12) begin
          len = MAX_KEY;
        end else if (pick < 25) begin
          len = $urandom_range(MAX_KEY - 1, 9);
        end else begin
          len = $urandom_range(8, 1);
        end
        k.len = 8'(len);
        for (int unsigned n = 0; n < len; n++) begin
          pick = $urandom_range(9);
          if (pick < 3) begin
            k.text[n] = LOWER_A + 8'($urandom_range(5));
          end else if (pick < 5) begin
            k.text[n] = LOWER_A - CASE_OFFSET + 8'($urandom_range(5));
          end else begin
            k.text[n] = 8'($urandom_range(255, 1));
          end
        end
        q = 1'($urandom_range(1));
      end
      if (q == REQ_ADD && k.len <= MAX_KEY) begin
        key_pool.push_back(k);
        if (key_pool.size() > 64) begin
          void'(key_pool.pop_front());
        end
      end
      for (int unsigned n = 0; n < k.len; n++) begin
        push_beat(q, k.text[n], n == k.len - 1, 1'b0, NO_VERDICT);
      end
      beats += k.len;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[bloom_filter_fnv1a_double_hash_unit.f]
sv/bfh_pkg.sv
sv/bfh_ram.sv
sv/bfh_key_unit.sv
sv/bfh_probe_unit.sv
sv/bloom_filter_fnv1a_double_hash_unit.sv
tb/tb_bloom_filter_fnv1a_double_hash_unit.sv
